// ===== rtl/core/hpfc_pkg.sv =====
// hpfc_pkg: shared types, codes and sizes for the heap pointer free checker
// used by heap_pointer_free_checker; depends on nothing

package hpfc_pkg;

  // SLOT_COUNT must be a power of two, the home slot is taken by masking
  localparam int unsigned SLOT_COUNT = 16384;
  localparam int unsigned RING_DEPTH = 4096;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SLOT_AW = $clog2(SLOT_COUNT);
  localparam int unsigned RING_AW = $clog2(RING_DEPTH);
  localparam int unsigned RING_CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned HASH_W  = 28;

  localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(SLOT_COUNT - 1);
  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);
  localparam logic [RING_CW-1:0] RING_FULL = RING_CW'(RING_DEPTH);

  typedef logic [1:0] tag_t;
  localparam tag_t TAG_EMPTY = 2'd0;
  localparam tag_t TAG_LIVE  = 2'd1;
  localparam tag_t TAG_TOMB  = 2'd2;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_ALLOC   = 2'd0;
  localparam opcode_t OP_REALLOC = 2'd1;
  localparam opcode_t OP_FREE    = 2'd2;

  typedef logic [2:0] verdict_t;
  localparam verdict_t V_TRACKED = 3'd0;
  localparam verdict_t V_NULL    = 3'd1;
  localparam verdict_t V_EARLY   = 3'd2;
  localparam verdict_t V_DOUBLE  = 3'd3;
  localparam verdict_t V_NEVER   = 3'd4;
  localparam verdict_t V_NORMAL  = 3'd5;

  typedef struct packed {
    tag_t              tag;
    logic [ADDR_W-1:0] addr;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // home slot: ((a >> 4) ^ (a >> 16)) mod SLOT_COUNT
  function automatic logic [SLOT_AW-1:0] home_slot(input logic [ADDR_W-1:0] a);
    logic [HASH_W-1:0] h;
    h = a[ADDR_W-1:4] ^ {12'd0, a[ADDR_W-1:16]};
    return h[SLOT_AW-1:0];
  endfunction

endpackage

// ===== rtl/core/heap_pointer_free_checker.sv =====
// heap_pointer_free_checker: top level, sequencer around the slot table and free ring
// depends on hpfc_pkg and hpfc_ram

// Checks allocator events one at a time and returns one result word per input word.
// After reset a clearing pass writes all SLOT_COUNT slots (16384) empty; in_stall
// stays high until it is done. An event then ends in S_DONE; each hash table walk
// issues the home slot read in S_HASH, then probes in S_LOOK or S_INS (one slot ram
// read per cycle). A realloc with both addresses nonzero walks the table twice. A
// free of an address that is not live, once an alloc or realloc has been seen, also
// scans the free ring, one ring ram read per cycle over the entries written so far
// (up to RING_DEPTH). Null frees, early frees, allocs of a null address, reallocs of
// two null addresses and the unused opcode finish without a walk. A finished result
// sits in the output register while the next event is accepted; while the receiver
// still holds an earlier result, the event waits in S_DONE with in_stall high.

module heap_pointer_free_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  hpfc_pkg::opcode_t         in_opcode,
  input  logic [31:0]               in_returned_addr,
  input  logic [31:0]               in_given_addr,
  input  logic [31:0]               in_req_size,
  output logic                      out_valid,
  input  logic                      out_stall,
  output hpfc_pkg::verdict_t        out_verdict,
  output logic [31:0]               out_free_number,
  output logic                      out_table_full
);

  import hpfc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_RING  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  opcode_t            op_r, op_nxt;
  logic [ADDR_W-1:0]  ret_r, ret_nxt;
  logic [ADDR_W-1:0]  given_r, given_nxt;
  logic               size_zero_r, size_zero_nxt;
  logic [SLOT_AW-1:0] home_r, home_nxt;
  logic               ins_r, ins_nxt;
  logic [SLOT_AW-1:0] k_r, k_nxt;
  logic [SLOT_AW-1:0] pcnt_r, pcnt_nxt;
  logic [RING_AW-1:0] ridx_r, ridx_nxt;
  logic [RING_AW-1:0] ring_pos_r, ring_pos_nxt;
  logic               ring_wrap_r, ring_wrap_nxt;
  logic [ADDR_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic               seen_r, seen_nxt;
  verdict_t           res_verdict_r, res_verdict_nxt;
  logic               res_full_r, res_full_nxt;
  logic               out_valid_r, out_valid_nxt;
  verdict_t           out_verdict_r, out_verdict_nxt;
  logic [ADDR_W-1:0]  out_free_r, out_free_nxt;
  logic               out_full_r, out_full_nxt;

  // memory ports
  logic               slot_we, slot_re;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  slot_t              slot_wdata, slot_rdata;
  logic               ring_we, ring_re;
  logic [RING_AW-1:0] ring_waddr, ring_raddr;
  logic [ADDR_W-1:0]  ring_wdata, ring_rdata;

  // helpers
  logic [SLOT_AW-1:0] k_inc;
  logic [RING_CW-1:0] ring_limit;
  logic               ring_at_end;
  logic               start;
  logic [ADDR_W-1:0]  start_key;
  logic               start_ins;
  logic               finish;
  verdict_t           fin_verdict;
  logic               fin_full;

  hpfc_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  hpfc_ram #(.WIDTH(ADDR_W), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign k_inc       = (k_r == SLOT_LAST) ? '0 : k_r + 1'b1;
  // only ring entries written since reset are searched
  assign ring_limit  = ring_wrap_r ? RING_FULL : RING_CW'(ring_pos_r);
  assign ring_at_end = (RING_CW'(ridx_r) + RING_CW'(1)) == ring_limit;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_verdict     = out_verdict_r;
  assign out_free_number = out_free_r;
  assign out_table_full  = out_full_r;

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    ret_nxt         = ret_r;
    given_nxt       = given_r;
    size_zero_nxt   = size_zero_r;
    home_nxt        = home_r;
    ins_nxt         = ins_r;
    k_nxt           = k_r;
    pcnt_nxt        = pcnt_r;
    ridx_nxt        = ridx_r;
    ring_pos_nxt    = ring_pos_r;
    ring_wrap_nxt   = ring_wrap_r;
    free_cnt_nxt    = free_cnt_r;
    seen_nxt        = seen_r;
    res_verdict_nxt = res_verdict_r;
    res_full_nxt    = res_full_r;
    out_valid_nxt   = out_valid_r;
    out_verdict_nxt = out_verdict_r;
    out_free_nxt    = out_free_r;
    out_full_nxt    = out_full_r;

    slot_we    = 1'b0;
    slot_waddr = k_r;
    slot_wdata = '{tag: TAG_EMPTY, addr: '0};
    slot_re    = 1'b0;
    slot_raddr = k_inc;
    ring_we    = 1'b0;
    ring_waddr = ring_pos_r;
    ring_wdata = given_r;
    ring_re    = 1'b0;
    ring_raddr = ridx_r + 1'b1;

    start       = 1'b0;
    start_key   = ret_r;
    start_ins   = 1'b1;
    finish      = 1'b0;
    fin_verdict = V_TRACKED;
    fin_full    = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        slot_we = 1'b1;
        k_nxt   = k_inc;
        if (k_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_opcode;
          ret_nxt       = in_returned_addr;
          given_nxt     = in_given_addr;
          size_zero_nxt = (in_req_size == '0);
          unique case (in_opcode)
            OP_ALLOC: begin
              seen_nxt = 1'b1;
              if (in_returned_addr != '0) begin
                start     = 1'b1;
                start_key = in_returned_addr;
              end else begin
                finish = 1'b1;
              end
            end
            OP_REALLOC: begin
              seen_nxt = 1'b1;
              if (in_given_addr != '0) begin
                start     = 1'b1;
                start_key = in_given_addr;
                start_ins = 1'b0;
              end else if (in_returned_addr != '0) begin
                start     = 1'b1;
                start_key = in_returned_addr;
              end else begin
                finish = 1'b1;
              end
            end
            OP_FREE: begin
              if (in_given_addr == '0) begin
                finish      = 1'b1;
                fin_verdict = V_NULL;
              end else begin
                free_cnt_nxt = free_cnt_r + 32'd1;
                if (!seen_r) begin
                  finish      = 1'b1;
                  fin_verdict = V_EARLY;
                end else begin
                  start     = 1'b1;
                  start_key = in_given_addr;
                  start_ins = 1'b0;
                end
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      // S_HASH sits between the walks so a tombstone written by the lookup lands
      // before the insert reads the table
      S_HASH: begin
        k_nxt      = home_r;
        pcnt_nxt   = '0;
        slot_re    = 1'b1;
        slot_raddr = home_r;
        state_nxt  = ins_r ? S_INS : S_LOOK;
      end

      S_LOOK: begin
        if (slot_rdata.tag == TAG_LIVE && slot_rdata.addr == given_r) begin
          if (op_r == OP_FREE) begin
            slot_we       = 1'b1;
            slot_wdata    = '{tag: TAG_TOMB, addr: given_r};
            ring_we       = 1'b1;
            ring_pos_nxt  = (ring_pos_r == RING_LAST) ? '0 : ring_pos_r + 1'b1;
            ring_wrap_nxt = ring_wrap_r | (ring_pos_r == RING_LAST);
            finish        = 1'b1;
            fin_verdict   = V_NORMAL;
          end else begin
            if (ret_r != '0 || size_zero_r) begin
              slot_we    = 1'b1;
              slot_wdata = '{tag: TAG_TOMB, addr: given_r};
            end
            if (ret_r != '0) begin
              start = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
        end else if (slot_rdata.tag == TAG_EMPTY || pcnt_r == SLOT_LAST) begin
          // not live
          if (op_r == OP_FREE) begin
            if (ring_limit == '0) begin
              finish      = 1'b1;
              fin_verdict = V_NEVER;
            end else begin
              ridx_nxt   = '0;
              ring_re    = 1'b1;
              ring_raddr = '0;
              state_nxt  = S_RING;
            end
          end else if (ret_r != '0) begin
            start = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end else begin
          k_nxt    = k_inc;
          pcnt_nxt = pcnt_r + 1'b1;
          slot_re  = 1'b1;
        end
      end

      S_INS: begin
        if (slot_rdata.tag != TAG_LIVE || slot_rdata.addr == ret_r) begin
          slot_we    = 1'b1;
          slot_wdata = '{tag: TAG_LIVE, addr: ret_r};
          finish     = 1'b1;
        end else if (pcnt_r == SLOT_LAST) begin
          finish   = 1'b1;
          fin_full = 1'b1;
        end else begin
          k_nxt    = k_inc;
          pcnt_nxt = pcnt_r + 1'b1;
          slot_re  = 1'b1;
        end
      end

      S_RING: begin
        if (ring_rdata == given_r) begin
          finish      = 1'b1;
          fin_verdict = V_DOUBLE;
        end else if (ring_at_end) begin
          finish      = 1'b1;
          fin_verdict = V_NEVER;
        end else begin
          ridx_nxt = ridx_r + 1'b1;
          ring_re  = 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = res_verdict_r;
          out_free_nxt    = free_cnt_r;
          out_full_nxt    = res_full_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (start) begin
      home_nxt  = home_slot(start_key);
      ins_nxt   = start_ins;
      state_nxt = S_HASH;
    end
    if (finish) begin
      res_verdict_nxt = fin_verdict;
      res_full_nxt    = fin_full;
      state_nxt       = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      k_r         <= '0;
      ring_pos_r  <= '0;
      ring_wrap_r <= 1'b0;
      free_cnt_r  <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      ring_pos_r  <= ring_pos_nxt;
      ring_wrap_r <= ring_wrap_nxt;
      free_cnt_r  <= free_cnt_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    ret_r         <= ret_nxt;
    given_r       <= given_nxt;
    size_zero_r   <= size_zero_nxt;
    home_r        <= home_nxt;
    ins_r         <= ins_nxt;
    pcnt_r        <= pcnt_nxt;
    ridx_r        <= ridx_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_full_r    <= res_full_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_free_r    <= out_free_nxt;
    out_full_r    <= out_full_nxt;
  end

  a_slot_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we && slot_re |-> slot_waddr != slot_raddr)
    else $error("slot ram read and write hit the same entry");

  a_ring_with_tomb: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |-> slot_we && slot_wdata.tag == TAG_TOMB)
    else $error("ring write without tombstone write");

  a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && in_valid && in_opcode == OP_FREE && in_given_addr != '0
    |=> free_cnt_r == $past(free_cnt_r) + 32'd1)
    else $error("free counter did not advance on a non-null free");

  a_hash_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HASH |-> !slot_we && !ring_we)
    else $error("memory write during hash reduction");

  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !(out_valid_r && out_stall) |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not loaded into output register");

endmodule

// ===== rtl/core/hpfc_ram.sv =====
// hpfc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module hpfc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for heap_pointer_free_checker, with a shadow of the
// slot table and free ring that predicts unpinned result words; depends on hpfc_pkg

module testbench;
  import hpfc_pkg::*;

  localparam opcode_t     OP_UNUSED        = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned RANDOM_PER_PHASE = 250;
  localparam int unsigned DRAIN_CYCLES     = 100;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] number;
    logic        full;
  } free_result_t;

  typedef struct packed {
    opcode_t     op;
    logic [31:0] ret;
    logic [31:0] given;
    logic [31:0] size;
    bit          pinned;
    verdict_t    verdict;
    logic [31:0] number;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  opcode_t            in_opcode;
  logic [31:0]        in_returned_addr;
  logic [31:0]        in_given_addr;
  logic [31:0]        in_req_size;
  logic               out_valid;
  logic               out_stall;
  verdict_t           out_verdict;
  logic [31:0]        out_free_number;
  logic               out_table_full;

  // shadow state of the block
  tag_t               shadow_tag [SLOT_COUNT];
  logic [31:0]        shadow_addr [SLOT_COUNT];
  logic [31:0]        freed_log [RING_DEPTH];
  int unsigned        ring_wr;
  logic [31:0]        free_count;
  bit                 alloc_seen;

  free_result_t       pending_results[$];
  logic [31:0]        live_pool[$];
  logic [31:0]        freed_pool[$];
  bit                 word_taken;
  bit                 pin_next;
  free_result_t       pin_result;
  int                 error_count;
  int unsigned        idle_cycles;
  int                 idle_pct;
  int                 stall_pct;
  int                 hold_requests;
  int                 holds_done;

  // only the first rows carry typed-in results; the rest go through the shadow
  stim_row_t directed_rows [0:24] = '{
    '{OP_FREE,    32'h0,         32'h0,         32'h0,         1'b1, V_NULL,    32'd0},
    '{OP_FREE,    32'hFFFF_FFFF, 32'h0000_1000, 32'hFFFF_FFFF, 1'b1, V_EARLY,   32'd1},
    '{OP_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, V_TRACKED, 32'd1},
    '{OP_ALLOC,   32'h0,         32'h0,         32'h10,        1'b1, V_TRACKED, 32'd1},
    '{OP_ALLOC,   32'h0000_1000, 32'h0,         32'h20,        1'b1, V_TRACKED, 32'd1},
    '{OP_FREE,    32'h0,         32'h0000_1000, 32'h0,         1'b1, V_NORMAL,  32'd2},
    '{OP_FREE,    32'h0,         32'h0000_1000, 32'h0,         1'b1, V_DOUBLE,  32'd3},
    '{OP_FREE,    32'h0,         32'hDEAD_BEE0, 32'h0,         1'b1, V_NEVER,   32'd4},
    '{OP_ALLOC,   32'hFFFF_FFFF, 32'h0,         32'hFFFF_FFFF, 1'b0, V_TRACKED, 32'd0},
    '{OP_ALLOC,   32'hFFFF_FFFF, 32'h0,         32'h1,         1'b0, V_TRACKED, 32'd0},
    '{OP_FREE,    32'h0,         32'hFFFF_FFFF, 32'h0,         1'b0, V_TRACKED, 32'd0},
    '{OP_FREE,    32'h0,         32'hFFFF_FFFF, 32'h0,         1'b0, V_TRACKED, 32'd0},
    '{OP_ALLOC,   32'h0000_2000, 32'h0,         32'h8,         1'b0, V_TRACKED, 32'd0},
    '{OP_REALLOC, 32'h0000_3000, 32'h0000_2000, 32'h40,        1'b0, V_TRACKED, 32'd0},
    '{OP_FREE,    32'h0,         32'h0000_2000, 32'h0,         1'b0, V_TRACKED, 32'd0},
    '{OP_REALLOC, 32'h0000_4000, 32'h0,         32'h10,        1'b0, V_TRACKED, 32'd0},
    '{OP_REALLOC, 32'h0,         32'h0000_3000, 32'h0,         1'b0, V_TRACKED, 32'd0},
    '{OP_FREE,    32'h0,         32'h0000_3000, 32'h0,         1'b0, V_TRACKED, 32'd0},
    '{OP_REALLOC, 32'h0,         32'h0000_4000, 32'hFFFF_FFFF, 1'b0, V_TRACKED, 32'd0},
    '{OP_FREE,    32'h0,         32'h0000_4000, 32'h0,         1'b0, V_TRACKED, 32'd0},
    '{OP_REALLOC, 32'h0,         32'h0,         32'h0,         1'b0, V_TRACKED, 32'd0},
    // both land on home slot 5, so the second one probes past the first
    '{OP_ALLOC,   32'h0000_0050, 32'h0,         32'h30,        1'b0, V_TRACKED, 32'd0},
    '{OP_ALLOC,   32'h0004_0010, 32'h0,         32'h30,        1'b0, V_TRACKED, 32'd0},
    '{OP_FREE,    32'h0,         32'h0000_0050, 32'h0,         1'b0, V_TRACKED, 32'd0},
    '{OP_FREE,    32'h0,         32'h0004_0010, 32'h0,         1'b0, V_TRACKED, 32'd0}
  };

  heap_pointer_free_checker i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_returned_addr (in_returned_addr),
    .in_given_addr    (in_given_addr),
    .in_req_size      (in_req_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_free_number  (out_free_number),
    .out_table_full   (out_table_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned home_of(input logic [31:0] a);
    return ((a >> 4) ^ (a >> 16)) % SLOT_COUNT;
  endfunction

  function automatic bit find_live(input logic [31:0] a, output int unsigned where);
    int unsigned h;
    int unsigned k;
    h = home_of(a);
    where = 0;
    for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
      k = (h + i) % SLOT_COUNT;
      if (shadow_tag[k] == TAG_EMPTY) return 1'b0;
      if (shadow_tag[k] == TAG_LIVE && shadow_addr[k] == a) begin
        where = k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // returns 1 when no slot could take the address
  function automatic bit place_addr(input logic [31:0] a);
    int unsigned h;
    int unsigned k;
    if (a == 32'h0) return 1'b0;
    h = home_of(a);
    for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
      k = (h + i) % SLOT_COUNT;
      if (shadow_tag[k] != TAG_LIVE || shadow_addr[k] == a) begin
        shadow_tag[k] = TAG_LIVE;
        shadow_addr[k] = a;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void bury(input int unsigned k);
    shadow_tag[k] = TAG_TOMB;
  endfunction

  function automatic bit ring_holds(input logic [31:0] a);
    foreach (freed_log[i])
      if (freed_log[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void clear_shadow();
    foreach (shadow_tag[k]) begin
      shadow_tag[k] = TAG_EMPTY;
      shadow_addr[k] = '0;
    end
    foreach (freed_log[k]) freed_log[k] = '0;
    ring_wr = 0;
    free_count = '0;
    alloc_seen = 1'b0;
  endfunction

  function automatic free_result_t judge_event(input opcode_t op, input logic [31:0] ret,
                                               input logic [31:0] given,
                                               input logic [31:0] size);
    free_result_t r;
    int unsigned  k;
    bit           hit;
    r.verdict = V_TRACKED;
    r.full = 1'b0;
    k = 0;
    hit = 1'b0;
    case (op)
      OP_ALLOC: begin
        alloc_seen = 1'b1;
        r.full = place_addr(ret);
      end
      OP_REALLOC: begin
        // the old block is looked up before anything moves
        if (given != 32'h0) hit = find_live(given, k);
        alloc_seen = 1'b1;
        if (given != 32'h0 && ret != 32'h0) begin
          if (hit) bury(k);
          r.full = place_addr(ret);
        end else if (given == 32'h0 && ret != 32'h0) begin
          r.full = place_addr(ret);
        end else if (size == 32'h0 && given != 32'h0 && hit) begin
          bury(k);
        end
      end
      OP_FREE: begin
        if (given == 32'h0) begin
          r.verdict = V_NULL;
        end else begin
          free_count = free_count + 32'd1;
          hit = find_live(given, k);
          if (!alloc_seen) begin
            r.verdict = V_EARLY;
          end else if (!hit) begin
            r.verdict = ring_holds(given) ? V_DOUBLE : V_NEVER;
          end else begin
            bury(k);
            freed_log[ring_wr] = given;
            ring_wr = (ring_wr + 1) % RING_DEPTH;
            r.verdict = V_NORMAL;
          end
        end
      end
      default: ;
    endcase
    r.number = free_count;
    return r;
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      // small cluster of homes so probe chains and tombstones pile up
      default: return ($urandom_range(0, 3) << 18) | ($urandom_range(1, 64) << 4) |
                      $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [31:0] take_live();
    int          idx;
    logic [31:0] a;
    if (live_pool.size() == 0) return 32'h0;
    idx = $urandom_range(0, live_pool.size() - 1);
    a = live_pool[idx];
    live_pool.delete(idx);
    return a;
  endfunction

  task automatic send_word(input opcode_t op, input logic [31:0] ret, input logic [31:0] given,
                           input logic [31:0] size, input bit pinned,
                           input free_result_t pinned_val, input int gap);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_returned_addr <= ret;
    in_given_addr <= given;
    in_req_size <= size;
    pin_next = pinned;
    pin_result = pinned_val;
    do @(negedge clk); while (!word_taken);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    free_result_t want;
    word_taken = rst_n && in_valid && !in_stall;
    if (word_taken) begin
      want = judge_event(in_opcode, in_returned_addr, in_given_addr, in_req_size);
      if (pin_next) want = pin_result;
      pending_results.push_back(want);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: verdict %0d, free_number %0d",
               out_verdict, out_free_number);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_verdict);
          error_count++;
        end
        if (out_free_number !== want.number) begin
          $error("free_number: expected %0d, got %0d", want.number, out_free_number);
          error_count++;
        end
        if (out_table_full !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, out_table_full);
          error_count++;
        end
      end
    end
    if (word_taken || (rst_n && out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int           gap;
    int           sel;
    int           variant;
    opcode_t      op;
    logic [31:0]  ret;
    logic [31:0]  given;
    logic [31:0]  size;
    free_result_t row_result;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_ALLOC;
    in_returned_addr = '0;
    in_given_addr = '0;
    in_req_size = '0;
    pin_next = 1'b0;
    pin_result = '0;
    error_count = 0;
    idle_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    clear_shadow();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row_result = '{directed_rows[i].verdict, directed_rows[i].number, 1'b0};
      send_word(directed_rows[i].op, directed_rows[i].ret, directed_rows[i].given,
                directed_rows[i].size, directed_rows[i].pinned, row_result, 0);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 51 : (ph == 3) ? 22 : 0;
      stall_pct = (ph == 2) ? 51 : (ph == 3) ? 22 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 0 && n == RANDOM_PER_PHASE / 2) hold_requests++;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
        // fields an operation does not use still get random bits
        ret = $urandom;
        given = $urandom;
        size = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          op = OP_ALLOC;
          ret = ($urandom_range(0, 19) == 0) ? 32'h0 : pick_addr();
          if (ret != 32'h0) live_pool.push_back(ret);
        end else if (sel < 45) begin
          op = OP_REALLOC;
          variant = $urandom_range(0, 3);
          given = (variant == 1) ? 32'h0 : take_live();
          ret = (variant <= 1) ? pick_addr() : 32'h0;
          if (variant == 2) size = 32'h0;
          if (ret != 32'h0) live_pool.push_back(ret);
          // shrink to a nonzero size with no new block keeps the old one live
          if (variant == 3 && given != 32'h0 && size != 32'h0) live_pool.push_back(given);
        end else if (sel < 80) begin
          op = OP_FREE;
          given = take_live();
          if (given == 32'h0) given = pick_addr();
          freed_pool.push_back(given);
          if (freed_pool.size() > 64) void'(freed_pool.pop_front());
        end else if (sel < 88) begin
          op = OP_FREE;
          given = (freed_pool.size() != 0) ?
                  freed_pool[$urandom_range(0, freed_pool.size() - 1)] : pick_addr();
        end else if (sel < 93) begin
          op = OP_FREE;
          given = pick_addr();
        end else if (sel < 97) begin
          op = OP_FREE;
          given = 32'h0;
        end else begin
          op = OP_UNUSED;
        end
        send_word(op, ret, given, size, 1'b0, '0, gap);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
